@@ rtl/core/pidl_pkg.sv @@
// Package for the positional insert/delete list.
// Holds sizes, field widths, request and status codes, and the cell command type.
// No dependencies.
package pidl_pkg;

    // List sizing
    localparam int CAPACITY    = 64;
    localparam int ENTRY_WIDTH = 32;

    // Fixed port field widths
    localparam int MODE_W = 2;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;
    localparam int STAT_W = 2;

    // Derived widths
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [ENTRY_WIDTH-1:0] t_entry;
    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [CNT_W-1:0]       t_cnt;

    // Request modes
    typedef enum logic [MODE_W-1:0] {
        MODE_READ   = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_INSERT = 2'd2,
        MODE_DELETE = 2'd3
    } t_mode;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // Operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_DELETE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_idx     pos;
        t_entry   data;
    } t_cell_cmd;

endpackage

@@ rtl/core/positional_insert_delete_list_core.sv @@
// Positional insert/delete list, top level.
// A request's result is in the output register in the cycle after its transfer.
// One request per cycle unless the output stalls; shifting cells move in the same cycle.
// A new request is taken whenever the output register is empty or being drained.
// Reset (synchronous, active low) empties the list and the output register;
// entry contents are not cleared. Depends on pidl_pkg, pidl_chain.
module positional_insert_delete_list_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pidl_pkg::MODE_W-1:0]   i_mode,
    input  logic [pidl_pkg::POS_W-1:0]    i_position,
    input  logic [pidl_pkg::DATA_W-1:0]   i_item_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pidl_pkg::DATA_W-1:0]   o_read_value,
    output logic [pidl_pkg::LEN_W-1:0]    o_length,
    output logic [pidl_pkg::STAT_W-1:0]   o_status
);
    import pidl_pkg::*;

    t_cnt                r_count;
    t_cnt                n_count;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_read_value;
    logic [LEN_W-1:0]    r_length;
    t_status             r_status;
    t_status             n_status;
    logic                n_rd_sel;

    logic                w_accept;
    logic [EXT_W-1:0]    w_pos;
    logic [EXT_W-1:0]    w_cnt;
    t_cell_cmd           w_cmd;
    t_entry              w_rd_data;
    t_mode               w_mode;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pos      = EXT_W'(i_position);
    assign w_cnt      = EXT_W'(r_count);
    assign w_mode     = t_mode'(i_mode);

    // Request decode: range and full checks, cell command, next length
    always_comb begin
        n_count    = r_count;
        n_status   = STAT_OK;
        n_rd_sel   = 1'b0;
        w_cmd.op   = OP_HOLD;
        w_cmd.pos  = w_pos[IDX_W-1:0];
        w_cmd.data = t_entry'(i_item_value);
        unique case (w_mode)
            MODE_READ: begin
                if (w_pos < w_cnt) begin
                    n_rd_sel = 1'b1;
                end else begin
                    n_status = STAT_RANGE;
                end
            end
            MODE_WRITE: begin
                if (w_pos < w_cnt) begin
                    w_cmd.op = OP_WRITE;
                end else begin
                    n_status = STAT_RANGE;
                end
            end
            MODE_INSERT: begin
                if (w_pos > w_cnt) begin
                    n_status = STAT_RANGE;
                end else if (r_count >= t_cnt'(CAPACITY)) begin
                    n_status = STAT_FULL;
                end else begin
                    w_cmd.op = OP_INSERT;
                    n_count  = r_count + t_cnt'(1);
                end
            end
            MODE_DELETE: begin
                if (w_pos < w_cnt) begin
                    w_cmd.op = OP_DELETE;
                    n_count  = r_count - t_cnt'(1);
                end else begin
                    n_status = STAT_RANGE;
                end
            end
            default: begin
                n_status = STAT_RANGE;
            end
        endcase
        if (!w_accept) begin
            w_cmd.op = OP_HOLD;
            n_count  = r_count;
        end
    end

    pidl_chain u_chain (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_rd_idx  (w_pos[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Length and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= n_rd_sel ? DATA_W'(w_rd_data) : '0;
            r_length     <= LEN_W'(n_count);
            r_status     <= n_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_length     = r_length;
    assign o_status     = r_status;

    // Length never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(CAPACITY))
        else $error("list length above capacity");

    // Length changes only on a transfer
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("list length changed without a transfer");

    // A full report means the list really is full
    a_full_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == STAT_FULL) |-> r_count == t_cnt'(CAPACITY))
        else $error("full status with list not full");

    // A failed request returns zero data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != STAT_OK) |-> r_read_value == '0)
        else $error("nonzero read value on failed request");

endmodule

@@ rtl/core/pidl_cell.sv @@
// One storage cell of the list chain.
// Holds one entry and takes data from its left or right neighbor on shifts.
// Depends on pidl_pkg.
module pidl_cell (
    input  logic                i_clk,
    input  pidl_pkg::t_idx      i_index,
    input  pidl_pkg::t_cell_cmd i_cmd,
    input  pidl_pkg::t_entry    i_left,
    input  pidl_pkg::t_entry    i_right,
    output pidl_pkg::t_entry    o_value
);
    import pidl_pkg::*;

    t_entry r_value;
    t_entry n_value;

    // Next value from the broadcast command and this cell's place
    always_comb begin
        n_value = r_value;
        unique case (i_cmd.op)
            OP_HOLD: begin
                n_value = r_value;
            end
            OP_WRITE: begin
                if (i_index == i_cmd.pos) begin
                    n_value = i_cmd.data;
                end
            end
            OP_INSERT: begin
                if (i_index == i_cmd.pos) begin
                    n_value = i_cmd.data;
                end else if (i_index > i_cmd.pos) begin
                    n_value = i_left;
                end
            end
            OP_DELETE: begin
                if (i_index >= i_cmd.pos) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    // Entry storage, no reset
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

@@ rtl/core/pidl_chain.sv @@
// Row of list cells wired to their neighbors, plus the read selector.
// Depends on pidl_pkg and pidl_cell.
module pidl_chain (
    input  logic                i_clk,
    input  pidl_pkg::t_cell_cmd i_cmd,
    input  pidl_pkg::t_idx      i_rd_idx,
    output pidl_pkg::t_entry    o_rd_data
);
    import pidl_pkg::*;

    t_entry w_value [CAPACITY];

    // Cell row: each cell sees its neighbors, ends see zero
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_value[g+1];
        end

        pidl_cell u_cell (
            .i_clk   (i_clk),
            .i_index (t_idx'(g)),
            .i_cmd   (i_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_value[g])
        );
    end

    // Read selector over the cell outputs
    assign o_rd_data = w_value[i_rd_idx];

endmodule
